FILE: hw/rtl/deque_with_play_cursor_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the deque with play cursor
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_PLAY_CURSOR_TOP_ASSERT_SVH
`define DEQUE_WITH_PLAY_CURSOR_TOP_ASSERT_SVH
`ifndef SYNTH
// expr holds at every edge out of reset
`define DWPC_ASSERT_HOLDS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("dwpc check failed");
// cons holds in the cycle after ante
`define DWPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dwpc check failed");
`else
`define DWPC_ASSERT_HOLDS(lbl, expr)
`define DWPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/dwpc_pkg.sv
// ----------------------------------------------------------------------------
// dwpc_pkg
// Shared types and codes of the deque with play cursor.
// ----------------------------------------------------------------------------
`default_nettype none
package dwpc_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic [2:0] mode_t;
  typedef logic [1:0] status_t;

  localparam mode_t MODE_PUSH_BACK  = 3'd0;
  localparam mode_t MODE_PUSH_FRONT = 3'd1;
  localparam mode_t MODE_POP_BACK   = 3'd2;
  localparam mode_t MODE_POP_FRONT  = 3'd3;
  localparam mode_t MODE_NEXT       = 3'd4;
  localparam mode_t MODE_PREV       = 3'd5;
  localparam mode_t MODE_QUERY      = 3'd6;

  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_EMPTY = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic exec;  // apply the request to the indices and store
    logic rd;    // read the entry under the cursor
  } dp_cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/dwpc_ctrl.sv
// ----------------------------------------------------------------------------
// dwpc_ctrl
// Sequencer: accepts a request, then moves to the read state for the store read.
// ----------------------------------------------------------------------------
`default_nettype none
module dwpc_ctrl
  import dwpc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  output dp_cmd_t      cmd
);

`include "deque_with_play_cursor_top_assert.svh"

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs: take a request only when the result slot is free or frees now
  always_comb begin
    in_stall = 1'b1;
    cmd.rd   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = out_valid_r && out_stall;
      end
      ST_READ: begin
        cmd.rd = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    accept   = in_valid && !in_stall;
    cmd.exec = accept;
  end

  assign out_valid = out_valid_r;

  `DWPC_ASSERT_NEXT(a_exec_then_read, cmd.exec, state_r == ST_READ)
  `DWPC_ASSERT_HOLDS(a_slot_free_in_read, !(state_r == ST_READ) || !out_valid_r)
  `DWPC_ASSERT_NEXT(a_read_then_valid, state_r == ST_READ, out_valid_r)

endmodule
`default_nettype wire

FILE: hw/rtl/dwpc_dp.sv
// ----------------------------------------------------------------------------
// dwpc_dp
// Index registers, circular entry store and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module dwpc_dp
  import dwpc_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire dp_cmd_t                      cmd,
  input  wire mode_t                        in_mode,
  input  wire logic [DATA_W-1:0]            in_entry_id,
  output status_t                           out_status,
  output logic [$clog2(DEPTH+1)-1:0]        out_entry_count,
  output logic                              out_current_valid,
  output logic [DATA_W-1:0]                 out_current_entry
);

`include "deque_with_play_cursor_top_assert.svh"

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // the cursor is kept as an offset from the front entry
  logic [AW-1:0]     front_r, front_nxt;
  logic [AW-1:0]     off_r, off_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  status_t           status_r, status_nxt;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     front_dec;
  logic [AW-1:0]     front_inc;
  logic [CW-1:0]     off_ext;
  logic [CW-1:0]     off_inc_ext;
  logic [CW-1:0]     count_dec;
  logic              empty;
  logic              full;
  logic [DATA_W-1:0] entry_r;
  logic [DATA_W-1:0] mem [DEPTH];

  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign empty       = (count_r == '0);
  assign full        = (count_r >= CW'(DEPTH));
  assign front_dec   = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc   = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);
  assign off_ext     = CW'(off_r);
  assign off_inc_ext = off_ext + CW'(1);
  assign count_dec   = count_r - CW'(1);

  always_comb begin
    front_nxt  = front_r;
    off_nxt    = off_r;
    count_nxt  = count_r;
    status_nxt = STAT_OK;
    wr_en      = 1'b0;
    wr_addr    = slot_add(front_r, count_r[AW-1:0]);
    case (in_mode)
      MODE_PUSH_BACK: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
          if (empty) begin
            off_nxt = '0;
          end
        end
      end
      MODE_PUSH_FRONT: begin
        wr_addr = front_dec;
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          wr_en     = 1'b1;
          front_nxt = front_dec;
          count_nxt = count_r + CW'(1);
          off_nxt   = empty ? '0 : off_r + AW'(1);
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          count_nxt = count_dec;
          // cursor on the back entry wraps to the front
          if (off_ext == count_dec) begin
            off_nxt = '0;
          end
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          count_nxt = count_dec;
          front_nxt = front_inc;
          off_nxt   = (off_r == '0) ? '0 : off_r - AW'(1);
        end
      end
      MODE_NEXT: begin
        if (!empty) begin
          off_nxt = (off_inc_ext >= count_r) ? '0 : off_inc_ext[AW-1:0];
        end
      end
      MODE_PREV: begin
        if (count_r >= CW'(2)) begin
          off_nxt = (off_r == '0) ? count_dec[AW-1:0] : off_r - AW'(1);
        end
      end
      default: begin
        status_nxt = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      off_r    <= '0;
      count_r  <= '0;
      status_r <= STAT_OK;
    end else if (cmd.exec) begin
      front_r  <= front_nxt;
      off_r    <= off_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= in_entry_id;
    end
  end

  assign rd_addr = slot_add(front_r, off_r);

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      entry_r <= mem[rd_addr];
    end
  end

  assign out_status        = status_r;
  assign out_entry_count   = count_r;
  assign out_current_valid = !empty;
  assign out_current_entry = empty ? '0 : entry_r;

  `DWPC_ASSERT_HOLDS(a_count_bound, count_r <= CW'(DEPTH))
  `DWPC_ASSERT_HOLDS(a_cursor_in_range, empty || (off_ext < count_r))
  `DWPC_ASSERT_HOLDS(a_front_in_range, front_r <= AW'(DEPTH - 1))
  `DWPC_ASSERT_NEXT(a_hold_without_exec, !cmd.exec,
                    $stable(count_r) && $stable(front_r) && $stable(off_r))

endmodule
`default_nettype wire

FILE: hw/rtl/deque_with_play_cursor_top.sv
// ----------------------------------------------------------------------------
// deque_with_play_cursor_top
// Bounded deque of entry handles with a play cursor.
// After the request transfer the controller moves through the read state,
// a registered read of the store at the new cursor, and then raises out_valid.
// A new request is not taken while in the read state or while a result is
// held by out_stall.
// Reset: synchronous, active low; empties the queue, the store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module deque_with_play_cursor_top
  import dwpc_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire mode_t                        in_mode,
  input  wire logic [DATA_W-1:0]            in_entry_id,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output status_t                           out_status,
  output logic [$clog2(DEPTH+1)-1:0]        out_entry_count,
  output logic                              out_current_valid,
  output logic [DATA_W-1:0]                 out_current_entry
);

  dp_cmd_t cmd;

  dwpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  dwpc_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_mode           (in_mode),
    .in_entry_id       (in_entry_id),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count),
    .out_current_valid (out_current_valid),
    .out_current_entry (out_current_entry)
  );

endmodule
`default_nettype wire

FILE: bench/deque_with_play_cursor_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_with_play_cursor_top_tb
// Sends push, pop, cursor and query requests into the deque. Both channels
// idle at random. Each result is checked field by field against a
// behavioral copy of the deque and its play cursor. A short scripted
// sequence comes first and covers the empty, single-entry and full cases.
// Random phases follow that fill, drain or churn the queue.
// ----------------------------------------------------------------------------
module deque_with_play_cursor_top_tb
  import dwpc_pkg::*;
();

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned IDX_W        = $clog2(DEPTH);
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1);
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam mode_t       MODE_UNUSED  = 3'd7;
  localparam mode_t       NAV_MODES [4] = '{MODE_NEXT, MODE_PREV, MODE_QUERY, MODE_UNUSED};

  typedef struct packed {
    status_t           status;
    logic [CNT_W-1:0]  count;
    logic              valid;
    logic [DATA_W-1:0] entry;
  } deque_view_t;

  typedef struct {
    mode_t             mode;
    logic [DATA_W-1:0] id;
    int unsigned       reps;   // >1: repeat with random handles
    bit                typed;  // use the typed-in view instead of the predictor
    deque_view_t       view;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  wire logic                in_stall;
  mode_t                    in_mode = MODE_QUERY;
  logic [DATA_W-1:0]        in_entry_id = '0;
  wire logic                out_valid;
  logic                     out_stall = 1'b0;
  wire status_t             out_status;
  wire logic [CNT_W-1:0]    out_entry_count;
  wire logic                out_current_valid;
  wire logic [DATA_W-1:0]   out_current_entry;

  // behavioral copy of the deque
  logic [DATA_W-1:0] deque_store [DEPTH];
  logic [IDX_W-1:0]  deque_front = '0;
  logic [IDX_W-1:0]  deque_cursor = '0;
  logic [CNT_W-1:0]  deque_count = '0;

  deque_view_t pending_views [$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_hold = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;

  stim_row_t script [25] = '{
    '{MODE_QUERY,      32'h0,        1,  1'b1, {STAT_OK,    7'd0,  1'b0, 32'h0}},
    '{MODE_POP_BACK,   32'h0,        1,  1'b1, {STAT_EMPTY, 7'd0,  1'b0, 32'h0}},
    '{MODE_POP_FRONT,  32'h0,        1,  1'b1, {STAT_EMPTY, 7'd0,  1'b0, 32'h0}},
    '{MODE_NEXT,       32'h0,        1,  1'b1, {STAT_OK,    7'd0,  1'b0, 32'h0}},
    '{MODE_PREV,       32'h0,        1,  1'b1, {STAT_OK,    7'd0,  1'b0, 32'h0}},
    '{MODE_UNUSED,     32'hFFFFFFFF, 1,  1'b1, {STAT_OK,    7'd0,  1'b0, 32'h0}},
    '{MODE_PUSH_BACK,  32'hFFFFFFFF, 1,  1'b1, {STAT_OK,    7'd1,  1'b1, 32'hFFFFFFFF}},
    '{MODE_PREV,       32'h0,        1,  1'b1, {STAT_OK,    7'd1,  1'b1, 32'hFFFFFFFF}},
    '{MODE_NEXT,       32'h0,        1,  1'b1, {STAT_OK,    7'd1,  1'b1, 32'hFFFFFFFF}},
    '{MODE_PUSH_FRONT, 32'h0,        1,  1'b1, {STAT_OK,    7'd2,  1'b1, 32'hFFFFFFFF}},
    '{MODE_PREV,       32'h0,        1,  1'b1, {STAT_OK,    7'd2,  1'b1, 32'h0}},
    '{MODE_PUSH_BACK,  32'hA5A5A5A5, 1,  1'b0, '0},
    '{MODE_PREV,       32'h0,        1,  1'b0, '0},
    '{MODE_POP_BACK,   32'h0,        1,  1'b0, '0},
    '{MODE_POP_FRONT,  32'h0,        1,  1'b0, '0},
    '{MODE_POP_FRONT,  32'h0,        1,  1'b1, {STAT_OK,    7'd0,  1'b0, 32'h0}},
    '{MODE_PUSH_FRONT, 32'h5A5A5A5A, 1,  1'b1, {STAT_OK,    7'd1,  1'b1, 32'h5A5A5A5A}},
    '{MODE_UNUSED,     32'h0,        1,  1'b1, {STAT_OK,    7'd1,  1'b1, 32'h5A5A5A5A}},
    '{MODE_PUSH_BACK,  32'h0,        63, 1'b0, '0},
    '{MODE_PUSH_BACK,  32'h12345678, 1,  1'b1, {STAT_FULL,  7'd64, 1'b1, 32'h5A5A5A5A}},
    '{MODE_PUSH_FRONT, 32'h0,        1,  1'b1, {STAT_FULL,  7'd64, 1'b1, 32'h5A5A5A5A}},
    '{MODE_PREV,       32'h0,        1,  1'b0, '0},
    '{MODE_POP_FRONT,  32'h0,        1,  1'b0, '0},
    '{MODE_POP_BACK,   32'h0,        63, 1'b0, '0},
    '{MODE_QUERY,      32'h0,        1,  1'b1, {STAT_OK,    7'd0,  1'b0, 32'h0}}
  };

  deque_with_play_cursor_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_entry_id      (in_entry_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_current_valid(out_current_valid),
    .out_current_entry(out_current_entry)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // advance the cursor one entry, wrapping to the front
  function automatic void cursor_forward();
    logic [IDX_W-1:0] rel;
    int unsigned      off;
    rel = deque_cursor - deque_front;
    off = rel + 1;
    if (off >= deque_count) off = 0;
    if (deque_count != 0) deque_cursor = deque_front + off[IDX_W-1:0];
  endfunction

  // step the cursor back one entry, wrapping to the back
  function automatic void cursor_backward();
    logic [IDX_W-1:0] rel;
    int unsigned      off;
    rel = deque_cursor - deque_front;
    off = (rel == 0 || rel >= deque_count) ? deque_count - 1 : rel - 1;
    if (deque_count >= 2) deque_cursor = deque_front + off[IDX_W-1:0];
  endfunction

  function automatic deque_view_t apply_request(mode_t m, logic [DATA_W-1:0] id);
    deque_view_t      v;
    logic [IDX_W-1:0] slot;
    v.status = STAT_OK;
    case (m)
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (deque_count == DEPTH) v.status = STAT_FULL;
        else begin
          if (m == MODE_PUSH_BACK) slot = deque_front + deque_count[IDX_W-1:0];
          else begin
            deque_front = deque_front - 1'b1;
            slot = deque_front;
          end
          deque_store[slot] = id;
          if (deque_count == 0) deque_cursor = slot;
          deque_count = deque_count + 1'b1;
        end
      end
      MODE_POP_BACK: begin
        if (deque_count == 0) v.status = STAT_EMPTY;
        else begin
          slot = deque_front + deque_count[IDX_W-1:0] - 1'b1;
          if (deque_cursor == slot) cursor_forward();
          deque_count = deque_count - 1'b1;
        end
      end
      MODE_POP_FRONT: begin
        if (deque_count == 0) v.status = STAT_EMPTY;
        else begin
          if (deque_cursor == deque_front) cursor_forward();
          deque_front = deque_front + 1'b1;
          deque_count = deque_count - 1'b1;
        end
      end
      MODE_NEXT: cursor_forward();
      MODE_PREV: cursor_backward();
      default: ;
    endcase
    v.count = deque_count;
    v.valid = (deque_count != 0);
    v.entry = v.valid ? deque_store[deque_cursor] : '0;
    return v;
  endfunction

  // hold the request until the transfer, then log what it should return
  task automatic send_request(mode_t m, logic [DATA_W-1:0] id, bit typed,
                              deque_view_t typed_view);
    int unsigned gap;
    deque_view_t predicted;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= m;
    in_entry_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_request(m, id);
    pending_views.push_back(typed ? typed_view : predicted);
  endtask

  task automatic compare_view(deque_view_t got);
    deque_view_t want;
    if (pending_views.size() == 0) begin
      $display("%0t: unexpected result status %0d count %0d valid %0d entry %h",
               $time, got.status, got.count, got.valid, got.entry);
      fail_count++;
      return;
    end
    want = pending_views.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      fail_count++;
    end
    if (got.count !== want.count) begin
      $display("%0t: entry_count expected %0d actual %0d", $time, want.count, got.count);
      fail_count++;
    end
    if (got.valid !== want.valid) begin
      $display("%0t: current_valid expected %0d actual %0d", $time, want.valid, got.valid);
      fail_count++;
    end
    if (got.entry !== want.entry) begin
      $display("%0t: current_entry expected %h actual %h", $time, want.entry, got.entry);
      fail_count++;
    end
  endtask

  // result side: check each transfer, then stall for a random number of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        compare_view({out_status, out_entry_count, out_current_valid, out_current_entry});
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        rx_hold = rx_quiet ? 0 : $urandom_range(0, 11);
      end else if (out_valid && rx_hold != 0) begin
        rx_hold--;
      end
      out_stall <= (rx_hold != 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned       sent;
    int unsigned       phase;
    int unsigned       len;
    int unsigned       r;
    int unsigned       push_pct;
    int unsigned       pop_pct;
    mode_t             m;
    logic [DATA_W-1:0] id;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      for (int unsigned k = 0; k < script[i].reps; k++) begin
        send_request(script[i].mode, (script[i].reps > 1) ? $urandom : script[i].id,
                     script[i].typed, script[i].view);
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      len = $urandom_range(60, 160);
      case ($urandom_range(0, 3))
        1: begin
          push_pct = 10;
          pop_pct  = 85;
        end
        2: begin
          push_pct = 40;
          pop_pct  = 75;
        end
        default: begin
          push_pct = 85;
          pop_pct  = 90;
        end
      endcase
      tx_quiet = ($urandom_range(0, 3) == 0);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < push_pct) m = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
        else if (r < pop_pct) m = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
        else m = NAV_MODES[$urandom_range(0, 3)];
        case ($urandom_range(0, 7))
          0: id = '0;
          1: id = '1;
          default: id = $urandom;
        endcase
        send_request(m, id, 1'b0, '0);
        sent++;
      end
      phase++;
      // hold off the sender until every outstanding result has drained
      if (phase % 3 == 1) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_views.size() != 0);
      end
    end

    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
